FILE: rtl/core/pose_delta_speed_steering_estimator_assert.svh
// assertion macros for the pose delta speed and steering estimator
// expects clk and rst_n in the scope of the including module
`ifndef POSE_DELTA_SPEED_STEERING_ESTIMATOR_ASSERT_SVH
`define POSE_DELTA_SPEED_STEERING_ESTIMATOR_ASSERT_SVH

// same cycle implication
`define PDSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication
`define PDSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pdse_pkg.sv
// shared types, constants and angle helpers for the pose delta estimator
// no dependencies
`default_nettype none

package pdse_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STEPS    = 16;

  localparam int ZW        = ANGLE_FRAC_BITS + 6;
  localparam int CW        = 49;
  localparam int SI_W      = $clog2(CORDIC_STEPS);
  localparam int DIV_W     = 54;
  localparam int DEN_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef logic signed [ZW-1:0] ang_t;
  typedef logic signed [ZW:0]   ang_w_t;
  typedef logic signed [CW-1:0] cord_t;
  typedef logic [1:0]           cfg_idx_t;

  localparam cfg_idx_t REG_WHEELBASE = 2'd0;
  localparam cfg_idx_t REG_GAP_LIMIT = 2'd1;
  localparam cfg_idx_t REG_MIN_SPEED = 2'd2;

  localparam logic [63:0] PI_Q62   = 64'hC90FDAA22168C235;
  localparam logic [63:0] PI_WIDE  = ((PI_Q62 >> (61 - ANGLE_FRAC_BITS)) + 64'd1) >> 1;
  localparam logic [63:0] QPI_WIDE = ((PI_Q62 >> (63 - ANGLE_FRAC_BITS)) + 64'd1) >> 1;

  localparam ang_w_t PI_FIX     = ang_w_t'(PI_WIDE);
  localparam ang_w_t TWO_PI     = ang_w_t'(PI_WIDE << 1);
  localparam ang_t   QUARTER_PI = ang_t'(QPI_WIDE);

  localparam logic [31:0] MICRO     = 32'd1000000;
  localparam logic [30:0] SPEED_MAX = 31'h7FFFFFFF;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DIR, S_DIR_W, S_MX, S_MY, S_ROOT, S_ROOT_W, S_MD,
    S_DIVS, S_DIVS_W, S_MW, S_ML, S_MR, S_DIVR, S_DIVR_W, S_STEER, S_STEER_W,
    S_DONE
  } state_t;

  function automatic ang_t atan_step(input logic [4:0] i);
    logic [31:0] t;
    t = ATAN_Q30[i];
    return ang_t'((t + 32'(1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS));
  endfunction

  // reduce to (-pi, pi] for values within four pi
  function automatic ang_t wrap_ang(input ang_w_t a);
    ang_w_t r;
    r = a;
    if (r >= TWO_PI) begin
      r = r - TWO_PI;
    end else if (r <= -TWO_PI) begin
      r = r + TWO_PI;
    end
    if (r > PI_FIX) begin
      r = r - TWO_PI;
    end else if (r <= -PI_FIX) begin
      r = r + TWO_PI;
    end
    return ang_t'(r);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pdse_root.sv
// iterative integer square root, two radicand bits and one result bit per pass
// depends on pdse_pkg
`default_nettype none

module pdse_root (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] val,
  output logic             busy,
  output logic [31:0]      root
);
  import pdse_pkg::*;

  logic [63:0] v_r, r_r, bit_r, trial;
  logic        busy_r;

  assign trial = r_r + bit_r;
  assign busy  = busy_r;
  assign root  = r_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      v_r    <= val;
      r_r    <= 64'd0;
      bit_r  <= 64'd1 << 62;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
      if (bit_r[0]) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pdse_div.sv
// restoring divider, one quotient bit per cycle
// depends on pdse_pkg
`default_nettype none

module pdse_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [pdse_pkg::DIV_W-1:0]    num,
  input  wire logic [pdse_pkg::DEN_W-1:0]    den,
  output logic                               busy,
  output logic [pdse_pkg::DIV_W-1:0]         quo
);
  import pdse_pkg::*;

  logic [DEN_W-1:0]     rem_r, den_r;
  logic [DIV_W-1:0]     q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [DEN_W:0]       shifted, diff;

  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign busy    = busy_r;
  assign quo     = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      rem_r  <= '0;
      den_r  <= den;
      q_r    <= num;
      cnt_r  <= DIV_CNT_W'(DIV_W - 1);
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_r <= diff[DEN_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DEN_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pdse_cordic.sv
// vectoring cordic, one micro rotation per cycle, gives atan2(y, x)
// depends on pdse_pkg
`default_nettype none

module pdse_cordic (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire pdse_pkg::cord_t x_in,
  input  wire pdse_pkg::cord_t y_in,
  output logic                 busy,
  output pdse_pkg::ang_t       z_out
);
  import pdse_pkg::*;

  cord_t           x_r, y_r, xs, ys;
  ang_t            z_r, at;
  logic [SI_W-1:0] i_r;
  logic            busy_r;

  assign xs    = x_r >>> i_r;
  assign ys    = y_r >>> i_r;
  assign at    = atan_step(5'(i_r));
  assign busy  = busy_r;
  assign z_out = z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      i_r <= '0;
      if (x_in == '0 && y_in == '0) begin
        z_r    <= '0;
        busy_r <= 1'b0;
      end else begin
        busy_r <= 1'b1;
        if (x_in < 0) begin
          z_r <= (y_in >= 0) ? ang_t'(PI_FIX) : -ang_t'(PI_FIX);
          x_r <= -x_in;
          y_r <= -y_in;
        end else begin
          z_r <= '0;
          x_r <= x_in;
          y_r <= y_in;
        end
      end
    end else if (busy_r) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end
      i_r <= i_r + 1'b1;
      if (i_r == SI_W'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pose_delta_speed_steering_estimator.sv
// Pose delta speed and steering estimator. Each item is a planar pose with a
// microsecond stamp; one result item (signed speed, steering angle) follows per
// item. Items are taken one at a time: when the gap is unusable the check state
// goes straight to the done state; otherwise the speed path runs, and the
// steering path too when the speed is above the minimum (the heading cordic ends
// at once when the position did not change); the result may wait on out_stall.
// The next item can be taken in the cycle after the result is loaded. The time
// is set by the shared sequential units: an iterative square root, a divider run
// once for speed and once for yaw rate, and a 16-step cordic run once for heading
// of travel and once for steering, plus one shared registered multiplier.
// A finished result sits in the output register while the next item is taken.
// depends on pdse_pkg, pdse_root, pdse_div, pdse_cordic and the assert header
`default_nettype none

module pose_delta_speed_steering_estimator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [18:0] in_heading,
  input  wire logic [47:0]        in_stamp_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_speed,
  output logic signed [18:0]      out_steer_angle,
  input  wire logic               cfg_we,
  input  wire pdse_pkg::cfg_idx_t cfg_index,
  input  wire logic [31:0]        cfg_wdata
);
  import pdse_pkg::*;

  state_t state_r, state_nxt;

  logic [23:0] wheelbase_r;
  logic [31:0] gap_r;
  logic [30:0] min_speed_r;

  logic signed [31:0] last_x_r, last_y_r;
  ang_t               last_yaw_r;
  logic [47:0]        last_stamp_r;
  logic               seen_r;

  logic signed [32:0] dx_r, dy_r;
  ang_t               yaw_r, dyaw_r;
  logic signed [48:0] dt_r;
  logic [30:0]        ux_r, uy_r;
  logic               sh_r;
  logic [61:0]        sq_r;
  logic [32:0]        dist_r;
  logic [30:0]        mag_r;
  logic               neg_r;
  logic [31:0]        lr_r;
  logic [64:0]        p_r;
  logic [31:0]        res_speed_r;
  logic [18:0]        res_steer_r;
  logic [31:0]        out_speed_r;
  logic [18:0]        out_steer_r;
  logic               out_valid_r;

  ang_t               yaw_in, dyaw_in, dir_diff, dir_adiff, ady;
  logic signed [48:0] dt_in;
  logic signed [32:0] dx_in, dy_in, ax, ay;
  logic               dt_ok, in_acc, out_free, sh_in;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [DIV_W-1:0]   dthalf, div_num, div_quo;
  logic [30:0]        mag_nxt;
  logic [47:0]        lr_full;
  logic               root_start, div_start, cord_start;
  logic               root_busy, div_busy, cord_busy;
  logic [31:0]        root_q;
  cord_t              cord_x, cord_y;
  ang_t               cord_z;

  assign in_acc  = in_valid && !in_stall;
  assign yaw_in  = wrap_ang(ang_w_t'(in_heading));
  assign dyaw_in = wrap_ang(ang_w_t'(yaw_in) - ang_w_t'(last_yaw_r));
  assign dt_in   = $signed({1'b0, in_stamp_us}) -
                   $signed({1'b0, (seen_r ? last_stamp_r : in_stamp_us)});
  assign dx_in   = 33'(in_pos_x) - 33'(last_x_r);
  assign dy_in   = 33'(in_pos_y) - 33'(last_y_r);

  assign dt_ok   = !dt_r[48] && (dt_r != '0) && (dt_r[47:0] <= {16'd0, gap_r});
  assign ax      = dx_r[32] ? -dx_r : dx_r;
  assign ay      = dy_r[32] ? -dy_r : dy_r;
  assign sh_in   = ax[31] || ay[31];

  assign dir_diff  = wrap_ang(ang_w_t'(yaw_r) - ang_w_t'(cord_z));
  assign dir_adiff = (dir_diff < 0) ? -dir_diff : dir_diff;
  assign ady       = (dyaw_r < 0) ? -dyaw_r : dyaw_r;

  assign dthalf  = DIV_W'(dt_r[31:1]);
  assign div_num = p_r[DIV_W-1:0] + dthalf;
  assign mag_nxt = (div_quo > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[30:0];
  assign lr_full = (p_r[47:0] + 48'(1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;

  assign out_free        = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_speed       = out_speed_r;
  assign out_steer_angle = out_steer_r;

  pdse_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .val   (64'(sq_r) + 64'(p_r[61:0])),
    .busy  (root_busy),
    .root  (root_q)
  );

  pdse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dt_r[31:0]),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  pdse_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .x_in  (cord_x),
    .y_in  (cord_y),
    .busy  (cord_busy),
    .z_out (cord_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    root_start = 1'b0;
    div_start  = 1'b0;
    cord_start = 1'b0;
    cord_x     = cord_t'(dx_r);
    cord_y     = cord_t'(dy_r);
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = dt_ok ? S_DIR : S_DONE;
      end
      S_DIR: begin
        cord_start = 1'b1;
        state_nxt  = S_DIR_W;
      end
      S_DIR_W: begin
        if (!cord_busy) begin
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        mul_a     = 33'(ux_r);
        mul_b     = 32'(ux_r);
        state_nxt = S_MY;
      end
      S_MY: begin
        mul_a     = 33'(uy_r);
        mul_b     = 32'(uy_r);
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        root_start = 1'b1;
        state_nxt  = S_ROOT_W;
      end
      S_ROOT_W: begin
        if (!root_busy) begin
          state_nxt = S_MD;
        end
      end
      S_MD: begin
        mul_a     = dist_r;
        mul_b     = MICRO;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        div_start = 1'b1;
        state_nxt = S_DIVS_W;
      end
      S_DIVS_W: begin
        if (!div_busy) begin
          state_nxt = (mag_nxt > min_speed_r) ? S_MW : S_DONE;
        end
      end
      S_MW: begin
        mul_a     = 33'(wheelbase_r);
        mul_b     = 32'(ady);
        state_nxt = S_ML;
      end
      S_ML: begin
        state_nxt = S_MR;
      end
      S_MR: begin
        mul_a     = 33'(lr_r);
        mul_b     = MICRO;
        state_nxt = S_DIVR;
      end
      S_DIVR: begin
        div_start = 1'b1;
        state_nxt = S_DIVR_W;
      end
      S_DIVR_W: begin
        if (!div_busy) begin
          state_nxt = S_STEER;
        end
      end
      S_STEER: begin
        cord_start = 1'b1;
        cord_x     = cord_t'({1'b0, mag_r});
        cord_y     = cord_t'(div_quo);
        state_nxt  = S_STEER_W;
      end
      S_STEER_W: begin
        if (!cord_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheelbase_r <= 24'd172032;
      gap_r       <= 32'd3000000;
      min_speed_r <= 31'd1966;
    end else if (cfg_we) begin
      if (cfg_index == REG_WHEELBASE) begin
        wheelbase_r <= cfg_wdata[23:0];
      end else if (cfg_index == REG_GAP_LIMIT) begin
        gap_r <= cfg_wdata;
      end else if (cfg_index == REG_MIN_SPEED) begin
        min_speed_r <= cfg_wdata[30:0];
      end
    end
  end

  // previous pose
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r     <= '0;
      last_y_r     <= '0;
      last_yaw_r   <= '0;
      last_stamp_r <= '0;
      seen_r       <= 1'b0;
    end else if (in_acc) begin
      last_x_r     <= in_pos_x;
      last_y_r     <= in_pos_y;
      last_yaw_r   <= yaw_in;
      last_stamp_r <= in_stamp_us;
      seen_r       <= 1'b1;
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        dx_r   <= dx_in;
        dy_r   <= dy_in;
        yaw_r  <= yaw_in;
        dyaw_r <= dyaw_in;
        dt_r   <= dt_in;
      end
      S_CHECK: begin
        sh_r        <= sh_in;
        ux_r        <= sh_in ? ax[31:1] : ax[30:0];
        uy_r        <= sh_in ? ay[31:1] : ay[30:0];
        res_speed_r <= '0;
        res_steer_r <= '0;
      end
      S_DIR_W: begin
        neg_r <= dir_adiff > QUARTER_PI;
      end
      S_MY: begin
        sq_r <= p_r[61:0];
      end
      S_ROOT_W: begin
        dist_r <= sh_r ? {root_q, 1'b0} : {1'b0, root_q};
      end
      S_DIVS_W: begin
        mag_r       <= mag_nxt;
        res_speed_r <= neg_r ? (32'd0 - {1'b0, mag_nxt}) : {1'b0, mag_nxt};
        res_steer_r <= '0;
      end
      S_ML: begin
        lr_r <= lr_full[31:0];
      end
      S_STEER_W: begin
        res_steer_r <= (dyaw_r < 0) ? 19'(-cord_z) : 19'(cord_z);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
      out_speed_r <= res_speed_r;
      out_steer_r <= res_steer_r;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

`include "pose_delta_speed_steering_estimator_assert.svh"

  `PDSE_ASSERT_NXT(a_accept_busy, in_acc, in_stall, "item accepted but still ready")
  `PDSE_ASSERT_NXT(a_out_load, (state_r != S_DONE) && !out_valid_r, !out_valid_r,
                   "result appeared without completion")
  `PDSE_ASSERT_IMP(a_steer_speed, out_valid_r && (out_steer_r != '0), out_speed_r != '0,
                   "steering without speed")
  `PDSE_ASSERT_IMP(a_units_idle, state_r == S_IDLE, !div_busy && !root_busy && !cord_busy,
                   "unit busy while idle")

endmodule

`default_nettype wire

FILE: tb/tb_pose_delta_speed_steering_estimator.sv
// testbench for pose_delta_speed_steering_estimator: directed and random poses
// checked against a built-in predictor of speed and steering
// depends on pdse_pkg and the estimator rtl
`default_nettype none

module tb_pose_delta_speed_steering_estimator;
  import pdse_pkg::*;

  localparam longint unsigned PI_Q62_C = 64'hC90FDAA22168C235;
  localparam longint PI_V  = longint'(((PI_Q62_C >> 45) + 64'd1) >> 1);
  localparam longint QPI_V = longint'(((PI_Q62_C >> 47) + 64'd1) >> 1);
  localparam longint CYCLE_LIMIT = 3000000;

  localparam logic [31:0] ATAN_TAB [16] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF
  };

  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [18:0] steer;
  } motion_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, cfg_we;
  logic out_stall = 1'b0;
  logic signed [31:0] in_pos_x, in_pos_y, out_speed;
  logic signed [18:0] in_heading, out_steer_angle;
  logic [47:0] in_stamp_us;
  cfg_idx_t cfg_index;
  logic [31:0] cfg_wdata;

  motion_t motion_q[$];
  int fail_cnt = 0;
  longint cycles = 0;
  int burst_left = 0;
  int stall_run = 0;

  longint unsigned wheel_r, gap_lim_r, min_spd_r;
  longint prev_x, prev_y, prev_yaw;
  longint unsigned prev_stamp;
  bit seen_pose;
  logic [47:0] now_us;

  pose_delta_speed_steering_estimator DUT (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint wrap_pi(longint a);
    longint r;
    r = a % (2 * PI_V);
    if (r > PI_V) r -= 2 * PI_V;
    if (r <= -PI_V) r += 2 * PI_V;
    return r;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_V : -PI_V;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'((ATAN_TAB[i] + 32'd8192) >> 14);
      end else begin
        x -= ys; y += xs; z -= longint'((ATAN_TAB[i] + 32'd8192) >> 14);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic motion_t predict_motion(logic signed [31:0] px, logic signed [31:0] py,
                                             logic signed [18:0] ph, logic [47:0] ps);
    longint x, y, yaw, dt, dx, dy, dyaw, sp, st, diff;
    longint unsigned ux, uy, span, mag, lr, rate;
    int sh;
    motion_t m;
    x = px;
    y = py;
    yaw = wrap_pi(longint'(ph));
    sp = 0;
    st = 0;
    if (!seen_pose) prev_stamp = {16'd0, ps};
    dt = longint'({16'd0, ps}) - longint'(prev_stamp);
    if (dt > 0 && longint'(dt) <= longint'(gap_lim_r)) begin
      dx = x - prev_x;
      dy = y - prev_y;
      dyaw = wrap_pi(yaw - prev_yaw);
      ux = dx < 0 ? -dx : dx;
      uy = dy < 0 ? -dy : dy;
      sh = 0;
      if (ux >= 64'd2147483648 || uy >= 64'd2147483648) begin
        ux >>= 1; uy >>= 1; sh = 1;
      end
      span = int_root(ux * ux + uy * uy) << sh;
      mag = (span * 1000000 + longint'(dt) / 2) / longint'(dt);
      if (mag > 64'd2147483647) mag = 64'd2147483647;
      sp = mag;
      diff = wrap_pi(yaw - vec_angle(dy, dx));
      if (diff < 0) diff = -diff;
      if (diff > QPI_V) sp = -sp;
      if (mag > min_spd_r) begin
        lr = (wheel_r * (dyaw < 0 ? -dyaw : dyaw) + 64'd32768) >> 16;
        rate = (lr * 1000000 + longint'(dt) / 2) / longint'(dt);
        st = vec_angle(longint'(rate), longint'(mag));
        if (dyaw < 0) st = -st;
      end
    end
    prev_x = x;
    prev_y = y;
    prev_yaw = yaw;
    prev_stamp = {16'd0, ps};
    seen_pose = 1'b1;
    m.speed = sp[31:0];
    m.steer = st[18:0];
    return m;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pose_delta_speed_steering_estimator test failed");
      $finish;
    end
  end

  // random receiver stall pattern
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run <= $urandom_range(1, 40);
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      stall_run <= stall_run - 1;
      if (out_stall == 1'b0 && $urandom_range(0, 7) == 0) out_stall <= 1'b1;
      else if (out_stall && $urandom_range(0, 2) == 0) out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    motion_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (motion_q.size() == 0) begin
        $error("result item with none expected: speed %0d steer %0d",
               out_speed, out_steer_angle);
        fail_cnt++;
      end else begin
        e = motion_q.pop_front();
        if (out_speed !== e.speed) begin
          $error("speed expected %0d actual %0d", e.speed, out_speed);
          fail_cnt++;
        end
        if (out_steer_angle !== e.steer) begin
          $error("steer_angle expected %0d actual %0d", e.steer, out_steer_angle);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [18:0] ph, logic [47:0] ps);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_heading <= ph;
    in_stamp_us <= ps;
    now_us = ps;
    motion_q.push_back(predict_motion(px, py, ph, ps));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    int n;
    n = 0;
    in_valid <= 1'b0;
    burst_left = 0;
    while (motion_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (250) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_WHEELBASE: wheel_r = val[23:0];
      REG_GAP_LIMIT: gap_lim_r = val;
      REG_MIN_SPEED: min_spd_r = val[30:0];
      default: ;
    endcase
  endtask

  task automatic do_reset;
    in_valid <= 1'b0;
    in_pos_x <= '0;
    in_pos_y <= '0;
    in_heading <= '0;
    in_stamp_us <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_WHEELBASE;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    wheel_r = 172032;
    gap_lim_r = 3000000;
    min_spd_r = 1966;
    prev_x = 0;
    prev_y = 0;
    prev_yaw = 0;
    prev_stamp = 0;
    seen_pose = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_directed;
    send_pose(32'sd65536, -32'sd65536, 19'sd1000, 48'd5000000);
    send_pose(32'sd131072, -32'sd65536, 19'sd1000, 48'd5000000);
    send_pose(32'sd196608, 32'sd0, 19'sd12000, 48'd5033333);
    send_pose(32'sd100000, -32'sd50000, 19'sd12000, 48'd5066666);
    send_pose(32'sd100000, -32'sd50000, -19'sd30000, 48'd5100000);
    send_pose(32'sh80000000, 32'sh7FFFFFFF, 19'sh3FFFF, 48'd5100001);
    send_pose(32'sh7FFFFFFF, 32'sh80000000, 19'sh40000, 48'd5100002);
    send_pose(32'sh7FFFFFFF, 32'sh80000000, 19'sh40000, 48'd5100001);
    send_pose(32'sd0, 32'sd0, 19'sd0, 48'd8100001);
    send_pose(32'sd65536, 32'sd0, 19'sd205887, 48'd11100002);
    send_pose(32'sd70000, 32'sd3000, -19'sd205887, 48'd11100003);
    send_pose(32'sd70500, 32'sd3000, -19'sd1, 48'hFFFFFFFFFFFF);
    send_pose(32'sd71000, 32'sd3000, 19'sd0, 48'hFFFFFFFFFFFF);
    send_pose(32'sd71000, 32'sd3000, 19'sd0, 48'd0);
    send_pose(32'sd71030, 32'sd3000, 19'sd40, 48'd1000000);
    send_pose(32'sd71100, 32'sd3000, -19'sd40, 48'd1033333);
  endtask

  task automatic run_poses(int count);
    logic signed [31:0] px, py;
    logic signed [18:0] ph;
    int vx, vy, dh, seg, scale;
    int unsigned stp;
    px = $urandom;
    py = $urandom;
    ph = 19'($urandom_range(0, 411774) - 205887);
    seg = 0;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 12) begin
        send_pose(32'($urandom), 32'($urandom), 19'($urandom), 48'({$urandom, $urandom}));
        px = in_pos_x;
        continue;
      end
      if (seg == 0) begin
        seg = $urandom_range(4, 30);
        scale = $urandom_range(2, 22);
        vx = $urandom_range(0, 2 ** scale) - 2 ** (scale - 1);
        vy = $urandom_range(0, 2 ** scale) - 2 ** (scale - 1);
        dh = $urandom_range(0, 8000) - 4000;
      end
      seg--;
      px = px + vx + ($urandom_range(0, 64) - 32);
      py = py + vy + ($urandom_range(0, 64) - 32);
      ph = ($urandom_range(0, 19) == 0) ? 19'($urandom) : 19'(ph + dh);
      case ($urandom_range(0, 19))
        0: stp = 0;
        1: stp = 3000001;
        2: stp = $urandom_range(1, 50);
        default: stp = $urandom_range(1000, 100000);
      endcase
      send_pose(px, py, ph, now_us + stp);
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  task automatic test_reset_settings;
    run_poses(300);
  endtask

  task automatic test_wide_settings;
    set_reg(REG_WHEELBASE, 32'hFFFFFF);
    set_reg(REG_GAP_LIMIT, 32'hFFFFFFFF);
    set_reg(REG_MIN_SPEED, 32'd0);
    run_poses(250);
  endtask

  task automatic test_narrow_settings;
    set_reg(REG_WHEELBASE, 32'd0);
    set_reg(REG_GAP_LIMIT, 32'd0);
    set_reg(REG_MIN_SPEED, 32'h7FFFFFFF);
    run_poses(60);
    set_reg(REG_GAP_LIMIT, 32'd40000);
    run_poses(120);
  endtask

  task automatic test_mid_settings;
    set_reg(REG_WHEELBASE, 32'd98304);
    set_reg(REG_GAP_LIMIT, 32'd500000);
    set_reg(REG_MIN_SPEED, 32'd65536);
    run_poses(300);
  endtask

  initial begin
    do_reset();
    test_directed();
    test_reset_settings();
    test_wide_settings();
    test_narrow_settings();
    test_mid_settings();
    drain();
    if (fail_cnt == 0) begin
      $display("pose_delta_speed_steering_estimator test passed");
    end else begin
      $display("pose_delta_speed_steering_estimator test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
